// File: hdl/rpmc_pkg.sv
// Package for the Prim maze carver: beat structs, opcodes, directions.
// No dependencies.
package rpmc_pkg;

   localparam int unsigned CountWidth = 13;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_STEP  = 2'd1,
      OP_READ  = 2'd2,
      OP_BAD   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      DIR_NONE  = 3'd0,
      DIR_LEFT  = 3'd1,
      DIR_UP    = 3'd2,
      DIR_RIGHT = 3'd3,
      DIR_DOWN  = 3'd4
   } dir_type;

   localparam logic [1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_GRID_HEIGHT = 2'd1;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] random_value;
      logic [4:0]  cell_x;
      logic [4:0]  cell_y;
   } req_type;

   typedef struct packed {
      logic                  cell_value;
      logic                  carved;
      logic [CountWidth-1:0] frontier_count;
      logic                  generation_done;
      logic                  error_flag;
   } rsp_type;

endpackage

// File: hdl/rpmc_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module rpmc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata <= mem_ff[addr];
   end
endmodule

// File: hdl/rpmc_moddiv.sv
// Bit-serial remainder unit: 32-bit dividend modulo a count.
// Depends on rpmc_pkg.
module rpmc_moddiv (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [31:0]                    dividend,
   input  logic [rpmc_pkg::CountWidth-1:0] divisor,
   output logic                           busy,
   output logic [rpmc_pkg::CountWidth-1:0] remainder
);
   import rpmc_pkg::*;

   logic [31:0]           quot_ff, quot_in;
   logic [CountWidth:0]   rem_ff, rem_in;
   logic [CountWidth-1:0] div_ff, div_in;
   logic [5:0]            cnt_ff, cnt_in;
   logic [CountWidth:0]   trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      trial   = {rem_ff[CountWidth-1:0], quot_ff[31]};
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 6'd32;
      end else if (cnt_ff != 6'd0) begin
         quot_in = {quot_ff[30:0], 1'b0};
         rem_in  = (trial >= {1'b0, div_ff}) ? trial - {1'b0, div_ff} : trial;
         cnt_in  = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign busy      = (cnt_ff != 6'd0);
   assign remainder = rem_ff[CountWidth-1:0];
endmodule

// File: hdl/random_prim_maze_carver.sv
// Randomized Prim maze carver: cell grid and ordered frontier list in RAM.
// Handles one request at a time: a start clears the whole cell grid, a step
// picks an entry by remainder, shifts later frontier entries down and, when
// it carves, checks the four neighbours. Synchronous reset clears control and
// sweeps all MAX_WIDTH*MAX_HEIGHT grid cells first.
module random_prim_maze_carver #(
   parameter int unsigned MAX_WIDTH      = 32,
   parameter int unsigned MAX_HEIGHT     = 32,
   parameter int unsigned FRONTIER_DEPTH = 4096
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rpmc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rpmc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [5:0]        csr_wdata
);
   import rpmc_pkg::*;

   localparam int unsigned XW     = $clog2(MAX_WIDTH);
   localparam int unsigned YW     = $clog2(MAX_HEIGHT);
   localparam int unsigned CELLS  = MAX_WIDTH * MAX_HEIGHT;
   localparam int unsigned CW     = $clog2(CELLS);
   localparam int unsigned FW     = $clog2(FRONTIER_DEPTH);
   localparam int unsigned EW     = 3 + 8 + 8;
   localparam int unsigned SW     = FW + 1;

   typedef enum logic [14:0] {
      ST_CLEAR = 15'h0001, ST_IDLE  = 15'h0002, ST_READ  = 15'h0004,
      ST_RWAIT = 15'h0008, ST_MOD   = 15'h0010, ST_FETCH = 15'h0020,
      ST_FWAIT = 15'h0040, ST_SHRD  = 15'h0080, ST_SHWR  = 15'h0100,
      ST_TCHK  = 15'h0200, ST_TWAIT = 15'h0400, ST_CARVE = 15'h0800,
      ST_NBRD  = 15'h1000, ST_NBCK  = 15'h2000, ST_RESP  = 15'h4000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [5:0] gw_ff, gh_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gw_ff <= 6'd32;
         gh_ff <= 6'd32;
      end else if (csr_valid) begin
         if (csr_index == CSR_GRID_WIDTH)  gw_ff <= csr_wdata;
         if (csr_index == CSR_GRID_HEIGHT) gh_ff <= csr_wdata;
      end
   end
   logic [8:0] eff_w, eff_h;
   assign eff_w = (9'(gw_ff) > 9'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : 9'(gw_ff);
   assign eff_h = (9'(gh_ff) > 9'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : 9'(gh_ff);

   // working registers
   req_type       req_ff, req_in;
   rsp_type       rsp_ff, rsp_in;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] ptr_ff, ptr_in;       // shift / pick index
   logic [CW:0]   clr_ff, clr_in;
   logic [7:0]    tx_ff, tx_in, ty_ff, ty_in;
   logic [2:0]    dir_ff, dir_in;
   logic [1:0]    nb_ff, nb_in;

   // cell RAM
   logic          c_we;
   logic [CW-1:0] c_addr;
   logic          c_wd, c_rd;
   rpmc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cells (
      .clock(clock), .we(c_we), .addr(c_addr), .wdata(c_wd), .rdata(c_rd));

   // frontier RAM
   logic          f_we;
   logic [FW-1:0] f_addr;
   logic [EW-1:0] f_wd, f_rd;
   rpmc_ram #(.WIDTH(EW), .DEPTH(FRONTIER_DEPTH)) u_front (
      .clock(clock), .we(f_we), .addr(f_addr), .wdata(f_wd), .rdata(f_rd));

   logic                  m_start, m_busy;
   logic [CountWidth-1:0] m_rem;
   rpmc_moddiv u_mod (
      .clock(clock), .reset(reset), .start(m_start),
      .dividend(req_ff.random_value), .divisor(CountWidth'(size_ff)),
      .busy(m_busy), .remainder(m_rem));

   function automatic logic [CW-1:0] cidx(input logic [7:0] x, input logic [7:0] y);
      logic [YW-1:0] yy;
      logic [XW-1:0] xx;
      yy = y[YW-1:0];
      xx = x[XW-1:0];
      return CW'(yy) * CW'(MAX_WIDTH) + CW'(xx);
   endfunction

   // neighbor candidate for current nb_ff (left, up, right, down)
   logic [7:0] nx, ny;
   logic       n_ok;
   always_comb begin
      nx = tx_ff;
      ny = ty_ff;
      n_ok = 1'b0;
      unique case (nb_ff)
         2'd0: begin nx = tx_ff - 8'd2; n_ok = tx_ff >= 8'd2; end
         2'd1: begin ny = ty_ff - 8'd2; n_ok = ty_ff >= 8'd2; end
         2'd2: begin nx = tx_ff + 8'd2; n_ok = (9'(tx_ff) + 9'd2) < eff_w; end
         default: begin ny = ty_ff + 8'd2; n_ok = (9'(ty_ff) + 9'd2) < eff_h; end
      endcase
   end

   logic in_grid;
   assign in_grid = (9'(req_ff.cell_x) < eff_w) && (9'(req_ff.cell_y) < eff_h);

   logic [7:0] lx, ly;
   always_comb begin
      lx = tx_ff;
      ly = ty_ff;
      unique case (dir_ff)
         DIR_LEFT:  lx = tx_ff + 8'd1;
         DIR_UP:    ly = ty_ff + 8'd1;
         DIR_RIGHT: lx = tx_ff - 8'd1;
         DIR_DOWN:  ly = ty_ff - 8'd1;
         default:   ;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      req_in = req_ff; rsp_in = rsp_ff; size_in = size_ff; ptr_in = ptr_ff;
      clr_in = clr_ff; tx_in = tx_ff; ty_in = ty_ff; dir_in = dir_ff;
      nb_in = nb_ff;
      c_we = 1'b0; c_addr = cidx(req_ff.cell_x, req_ff.cell_y); c_wd = 1'b0;
      f_we = 1'b0; f_addr = ptr_ff[FW-1:0]; f_wd = '0;
      m_start = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            c_we = 1'b1; c_addr = clr_ff[CW-1:0];
            clr_in = clr_ff + 1'b1;
            if (clr_ff == (CW+1)'(CELLS - 1)) begin
               if (req_ff.operation == OP_START) begin
                  // seed list with start cell
                  f_we = 1'b1; f_addr = '0;
                  f_wd = {DIR_NONE, 3'b0, req_ff.cell_y, 3'b0, req_ff.cell_x};
                  size_in = SW'(1);
                  rsp_in = '{1'b0, 1'b0, CountWidth'(1), 1'b0, 1'b0};
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '{1'b0, 1'b0, CountWidth'(size_ff), size_ff == '0, 1'b0};
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            unique case (op_type'(req_ff.operation))
               OP_START: begin
                  if (in_grid) begin
                     clr_in = '0; state_in = ST_CLEAR;
                  end else begin
                     rsp_in.error_flag = 1'b1; state_in = ST_RESP;
                  end
               end
               OP_STEP: begin
                  if (size_ff == '0) state_in = ST_RESP;
                  else begin m_start = 1'b1; state_in = ST_MOD; end
               end
               OP_READ: begin
                  if (in_grid) state_in = ST_RWAIT;
                  else begin rsp_in.error_flag = 1'b1; state_in = ST_RESP; end
               end
               default: begin rsp_in.error_flag = 1'b1; state_in = ST_RESP; end
            endcase
         end
         ST_RWAIT: begin
            rsp_in.cell_value = c_rd; state_in = ST_RESP;
         end
         ST_MOD: begin
            if (!m_busy) begin
               ptr_in = SW'(m_rem); state_in = ST_FETCH;
            end
         end
         ST_FETCH: state_in = ST_FWAIT;
         ST_FWAIT: begin
            tx_in = f_rd[7:0]; ty_in = f_rd[15:8]; dir_in = f_rd[18:16];
            state_in = ST_SHRD;
         end
         ST_SHRD: begin
            // read entry ptr+1 for the ordered shift down
            if (ptr_ff + 1'b1 >= size_ff) begin
               size_in = size_ff - 1'b1; state_in = ST_TCHK;
            end else begin
               f_addr = FW'(ptr_ff + 1'b1); state_in = ST_SHWR;
            end
         end
         ST_SHWR: begin
            f_we = 1'b1; f_wd = f_rd; ptr_in = ptr_ff + 1'b1; state_in = ST_SHRD;
         end
         ST_TCHK: begin
            c_addr = cidx(tx_ff, ty_ff); state_in = ST_TWAIT;
         end
         ST_TWAIT: begin
            if (c_rd == 1'b0) begin
               c_we = 1'b1; c_wd = 1'b1; c_addr = cidx(lx, ly);
               state_in = ST_CARVE;
            end else state_in = ST_RESP;
         end
         ST_CARVE: begin
            c_we = 1'b1; c_wd = 1'b1; c_addr = cidx(tx_ff, ty_ff);
            rsp_in.carved = 1'b1; nb_in = 2'd0; state_in = ST_NBRD;
         end
         ST_NBRD: begin
            c_addr = cidx(nx, ny); state_in = ST_NBCK;
         end
         ST_NBCK: begin
            if (n_ok && c_rd == 1'b0 && size_ff < SW'(FRONTIER_DEPTH)) begin
               f_we = 1'b1; f_addr = size_ff[FW-1:0];
               f_wd = {3'(nb_ff) + 3'd1, ny, nx};
               size_in = size_ff + 1'b1;
            end
            nb_in = nb_ff + 2'd1;
            state_in = (nb_ff == 2'd3) ? ST_RESP : ST_NBRD;
         end
         ST_RESP: begin
            rsp_in.frontier_count  = CountWidth'(size_ff);
            rsp_in.generation_done = (size_ff == '0);
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff != ST_RESP && state_in == ST_RESP) begin
         rsp_in.frontier_count  = CountWidth'(size_in);
         rsp_in.generation_done = (size_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         size_ff  <= '0;
         clr_ff   <= '0;
         // not a start, so the power-up sweep ends in idle without a beat
         req_ff   <= '{operation: OP_BAD, default: '0};
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         clr_ff   <= clr_in;
         req_ff   <= req_in;
      end
      rsp_ff  <= rsp_in;
      ptr_ff  <= ptr_in;
      tx_ff   <= tx_in;
      ty_ff   <= ty_in;
      dir_ff  <= dir_in;
      nb_ff   <= nb_in;
   end
endmodule

// File: tb/sv/rpmc_checker.sv
// Checker for the Prim maze carver: mirrors grid, frontier list and grid size,
// predicts each response beat and compares. Depends on rpmc_pkg.
module rpmc_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  rpmc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rpmc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [5:0]        csr_wdata,
   output int                fail_count,
   output int                pending_count
);
   import rpmc_pkg::*;

   localparam int GridDim = 32;
   localparam int ListDepth = 4096;

   typedef struct packed {
      dir_type    link;
      logic [7:0] ty;
      logic [7:0] tx;
   } front_type;

   logic [5:0]  width_q, height_q;
   logic        cells [GridDim*GridDim];
   front_type   front_list [$];
   rsp_type     expected_rsps [$];

   assign pending_count = expected_rsps.size();

   function automatic int cell_at(int x, int y);
      return (y % GridDim) * GridDim + (x % GridDim);
   endfunction

   task automatic add_front(int x, int y, dir_type d);
      front_type f;
      if (front_list.size() >= ListDepth) return;
      f.link = d;
      f.ty = y[7:0];
      f.tx = x[7:0];
      front_list.insert(front_list.size(), f);
   endtask

   task automatic predict_carve(req_type r);
      rsp_type   e;
      int        w, h, pick, tx, ty, lx, ly;
      front_type f;
      w = (width_q > GridDim) ? GridDim : width_q;
      h = (height_q > GridDim) ? GridDim : height_q;
      e = '0;
      case (op_type'(r.operation))
         OP_START: begin
            if (r.cell_x >= w || r.cell_y >= h) begin
               e.error_flag = 1'b1;
            end else begin
               foreach (cells[i]) cells[i] = 1'b0;
               front_list.delete();
               add_front(r.cell_x, r.cell_y, DIR_NONE);
            end
         end
         OP_STEP: begin
            if (front_list.size() > 0) begin
               pick = r.random_value % front_list.size();
               f = front_list[pick];
               front_list.delete(pick);
               tx = f.tx;
               ty = f.ty;
               lx = tx;
               ly = ty;
               case (f.link)
                  DIR_LEFT:  lx = tx + 1;
                  DIR_UP:    ly = ty + 1;
                  DIR_RIGHT: lx = tx - 1;
                  DIR_DOWN:  ly = ty - 1;
                  default: ;
               endcase
               if (!cells[cell_at(tx, ty)]) begin
                  cells[cell_at(lx, ly)] = 1'b1;
                  cells[cell_at(tx, ty)] = 1'b1;
                  e.carved = 1'b1;
                  if (tx >= 2 && !cells[cell_at(tx-2, ty)]) add_front(tx-2, ty, DIR_LEFT);
                  if (ty >= 2 && !cells[cell_at(tx, ty-2)]) add_front(tx, ty-2, DIR_UP);
                  if (tx+2 < w && !cells[cell_at(tx+2, ty)]) add_front(tx+2, ty, DIR_RIGHT);
                  if (ty+2 < h && !cells[cell_at(tx, ty+2)]) add_front(tx, ty+2, DIR_DOWN);
               end
            end
         end
         OP_READ: begin
            if (r.cell_x >= w || r.cell_y >= h) e.error_flag = 1'b1;
            else e.cell_value = cells[cell_at(r.cell_x, r.cell_y)];
         end
         default: e.error_flag = 1'b1;
      endcase
      e.frontier_count = CountWidth'(front_list.size());
      e.generation_done = (front_list.size() == 0);
      expected_rsps.insert(expected_rsps.size(), e);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         width_q <= 6'd32;
         height_q <= 6'd32;
         foreach (cells[i]) cells[i] = 1'b0;
         front_list.delete();
         expected_rsps.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_GRID_WIDTH) width_q <= csr_wdata;
            else if (csr_index == CSR_GRID_HEIGHT) height_q <= csr_wdata;
         end
         // response first: it cannot belong to a beat accepted this edge
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               e = expected_rsps.pop_front();
               if (rsp_data.cell_value != e.cell_value)
                  report_mismatch("cell_value", rsp_data.cell_value, e.cell_value);
               if (rsp_data.carved != e.carved)
                  report_mismatch("carved", rsp_data.carved, e.carved);
               if (rsp_data.frontier_count != e.frontier_count)
                  report_mismatch("frontier_count", rsp_data.frontier_count,
                                  e.frontier_count);
               if (rsp_data.generation_done != e.generation_done)
                  report_mismatch("generation_done", rsp_data.generation_done,
                                  e.generation_done);
               if (rsp_data.error_flag != e.error_flag)
                  report_mismatch("error_flag", rsp_data.error_flag, e.error_flag);
            end
         end
         if (req_valid && !req_stall) predict_carve(req_data);
      end
   end
endmodule

// File: tb/sv/tb_random_prim_maze_carver.sv
// Top of the maze carver bench: clock, reset, stimulus, idling and verdict.
// Depends on rpmc_pkg, random_prim_maze_carver and rpmc_checker.
module tb_random_prim_maze_carver;
   import rpmc_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_index = '0;
   logic [5:0] csr_wdata = '0;
   int         fail_count, pending_count;

   // idle and stall rates, percent
   int send_idle = 0;
   int recv_stall = 0;
   bit hold_rsp = 1'b0;   // long receiver hold-off
   int cur_w = 32, cur_h = 32;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   random_prim_maze_carver dut (.*);

   rpmc_checker u_checker (.*);

   // receiver: random stall, or a long hold while hold_rsp is set
   always @(posedge clock) begin
      if (hold_rsp) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall);
   end

   // a long receiver hold-off counted in its own process
   task automatic hold_receiver(int cycles);
      hold_rsp = 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   // send one beat; valid stays up across back-to-back beats
   task automatic send_beat(op_type op, logic [31:0] rnd, logic [4:0] x, logic [4:0] y);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{operation: op, random_value: rnd, cell_x: x, cell_y: y};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      drop_valid();
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_grid(logic [5:0] w, logic [5:0] h);
      csr_valid <= 1'b1;
      csr_index <= CSR_GRID_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_index <= CSR_GRID_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      cur_w = (w > 32) ? 32 : w;
      cur_h = (h > 32) ? 32 : h;
   endtask

   // one random beat, mostly carve steps inside a running generation
   task automatic random_beat();
      int pct;
      pct = $urandom_range(99);
      if (pct < 70)
         send_beat(OP_STEP, $urandom, 5'($urandom), 5'($urandom));
      else if (pct < 85)
         send_beat(OP_READ, $urandom, 5'($urandom_range(cur_w > 0 ? cur_w - 1 : 0)),
                   5'($urandom_range(cur_h > 0 ? cur_h - 1 : 0)));
      else if (pct < 92)
         send_beat(OP_START, $urandom, 5'($urandom_range(cur_w > 0 ? cur_w - 1 : 0)),
                   5'($urandom_range(cur_h > 0 ? cur_h - 1 : 0)));
      else
         send_beat(op_type'($urandom_range(3)), $urandom, 5'($urandom), 5'($urandom));
   endtask

   // timeout covers the reset sweep and slow clears with wide margin
   initial begin
      #20000000;
      $display("tb_random_prim_maze_carver NOT OK");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: reset size 32x32, every op, the edge cases
      send_beat(OP_STEP, 32'hFFFF_FFFF, 5'd0, 5'd0);    // empty list
      send_beat(OP_READ, 32'd0, 5'd31, 5'd31);
      send_beat(OP_BAD, 32'hFFFF_FFFF, 5'd31, 5'd31);
      send_beat(OP_START, 32'd0, 5'd0, 5'd0);
      send_beat(OP_STEP, 32'd0, 5'd0, 5'd0);
      send_beat(OP_STEP, 32'hFFFF_FFFF, 5'd0, 5'd0);
      send_beat(OP_STEP, 32'h8000_0001, 5'd31, 5'd31);
      send_beat(OP_READ, 32'd0, 5'd0, 5'd0);
      send_beat(OP_READ, 32'd0, 5'd1, 5'd0);
      send_beat(OP_START, 32'd0, 5'd31, 5'd31);
      send_beat(OP_STEP, 32'd0, 5'd0, 5'd0);
      send_beat(OP_STEP, 32'd1, 5'd0, 5'd0);
      drain();

      // small grid: out-of-range start and read, then run to done
      write_grid(6'd2, 6'd3);
      send_beat(OP_START, 32'd0, 5'd2, 5'd0);
      send_beat(OP_READ, 32'd0, 5'd0, 5'd3);
      send_beat(OP_START, 32'd0, 5'd1, 5'd2);
      repeat (4) send_beat(OP_STEP, $urandom, 5'd0, 5'd0);
      send_beat(OP_READ, 32'd0, 5'd1, 5'd2);
      drain();

      // zero size: everything is outside; then shrink mid-generation
      write_grid(6'd0, 6'd0);
      send_beat(OP_READ, 32'd0, 5'd0, 5'd0);
      send_beat(OP_START, 32'd0, 5'd0, 5'd0);
      drain();
      write_grid(6'd63, 6'd40);   // above max counts as 32
      send_beat(OP_START, 32'd0, 5'd15, 5'd15);
      repeat (6) send_beat(OP_STEP, $urandom, 5'd0, 5'd0);
      drain();
      write_grid(6'd9, 6'd9);     // old entries stay, neighbours use new size
      repeat (4) send_beat(OP_STEP, $urandom, 5'd0, 5'd0);
      drain();

      // random phases: idle/stall mixes, grid sizes incl. extremes
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 45; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 45; end
            3: begin send_idle = 36; recv_stall = 36; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         case (ph)
            0: write_grid(6'd32, 6'd32);
            1: write_grid(6'd2, 6'd2);
            2: write_grid(6'($urandom_range(2, 32)), 6'($urandom_range(2, 32)));
            3: write_grid(6'd32, 6'd5);
            default: write_grid(6'($urandom_range(2, 20)), 6'($urandom_range(2, 20)));
         endcase
         send_beat(OP_START, $urandom, 5'($urandom_range(cur_w - 1)),
                   5'($urandom_range(cur_h - 1)));
         if (ph == 4) begin
            // receiver holds off past the grid clear while beats keep coming
            fork
               hold_receiver(1500);
            join_none
         end
         for (int i = 0; i < 20; i++) random_beat();
         // full pause until every expected result is back
         drain();
      end

      if (fail_count == 0) $display("tb_random_prim_maze_carver OK");
      else $display("tb_random_prim_maze_carver NOT OK");
      $finish;
   end
endmodule
